[hw/rtl/tgp_pkg.sv]
// Shared types, codes and constants of the turtle grid plotter.
package tgp_pkg;

  localparam int GRID_SIZE_DEF = 32;

  // Width of the shared step unit operands: holds a position plus a distance.
  localparam int STEP_W = 7;

  typedef enum logic [2:0] {
    REQ_PEN_UP     = 3'd0,
    REQ_PEN_DOWN   = 3'd1,
    REQ_TURN_RIGHT = 3'd2,
    REQ_TURN_LEFT  = 3'd3,
    REQ_MOVE       = 3'd4,
    REQ_READ       = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    CELL_BLANK = 2'd0,
    CELL_HORIZ = 2'd1,
    CELL_VERT  = 2'd2
  } cell_t;

  typedef enum logic [1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_DOWN  = 2'd1,
    HEAD_LEFT  = 2'd2,
    HEAD_UP    = 2'd3
  } heading_t;

  typedef enum logic {
    STEP_ADD = 1'b0,
    STEP_SUB = 1'b1
  } step_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WALK,
    ST_FLUSH,
    ST_RWAIT
  } state_t;

endpackage

[hw/rtl/tgp_grid_mem.sv]
// Cell grid memory: one write port, one read port with registered read data.
module tgp_grid_mem import tgp_pkg::*; #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output cell_t         rd_data_r
);

  cell_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/tgp_step_unit.sv]
// Shared step unit: add or subtract with borrow, for clamping and walking.
module tgp_step_unit import tgp_pkg::*; (
  input  step_op_t          op,
  input  logic [STEP_W-1:0] a,
  input  logic [STEP_W-1:0] b,
  output logic [STEP_W:0]   res
);

  // top bit set on a subtraction means the result went below zero
  always_comb begin
    unique case (op)
      STEP_ADD: res = {1'b0, a} + {1'b0, b};
      STEP_SUB: res = {1'b0, a} - {1'b0, b};
      default:  res = '0;
    endcase
  end

endmodule

[hw/rtl/turtle_grid_plotter_top.sv]
// Turtle grid plotter: pen, heading and position control over a cell grid memory.
// Pen, turn, unused codes and off-grid reads strobe the result in the cycle after start;
// other reads pass RWAIT; moves pass CALC, and pen-down moves then WALK each cell and FLUSH.
// Throughput: one command in flight; a pen-down move walks one cell per cycle through
// the grid memory (read, then write if blank). Results cannot be stalled.
// Reset: clears all 4**clog2(GRID_SIZE) cells of the grid (1024 at 32), busy high.
module turtle_grid_plotter_top import tgp_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_req_type,
  input  logic [5:0] in_steps,
  input  logic [4:0] in_read_row,
  input  logic [4:0] in_read_col,
  output logic       out_valid,
  output logic [1:0] out_cell_code,
  output logic [4:0] out_turtle_row,
  output logic [4:0] out_turtle_col,
  output logic [1:0] out_turtle_heading,
  output logic       out_pen_is_down
);

  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = 2 * CW;
  localparam logic [CW-1:0]     MAX_POS   = CW'(GRID_SIZE - 1);
  localparam logic [STEP_W-1:0] MAX_POS_W = STEP_W'(GRID_SIZE - 1);
  localparam logic [STEP_W-1:0] GRID_W    = STEP_W'(GRID_SIZE);

  state_t        state_r, state_nxt;
  logic [CW-1:0] pos_row_r, pos_row_nxt;
  logic [CW-1:0] pos_col_r, pos_col_nxt;
  heading_t      heading_r, heading_nxt;
  logic          pen_r, pen_nxt;
  cell_t         code_r, code_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    dist_r, dist_nxt;
  logic          horiz_r, horiz_nxt;
  logic          fwd_r, fwd_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  cell_t         mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  cell_t         mem_rd_data;

  step_op_t            step_op;
  logic [STEP_W-1:0]   step_a;
  logic [STEP_W-1:0]   step_b;
  logic [STEP_W:0]     step_res;

  logic [CW-1:0] start_pos;
  logic [CW-1:0] target;
  logic          accept;

  tgp_grid_mem #(
    .AW (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .rd_data_r (mem_rd_data)
  );

  tgp_step_unit u_step (
    .op  (step_op),
    .a   (step_a),
    .b   (step_b),
    .res (step_res)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign start_pos = horiz_r ? pos_col_r : pos_row_r;

  // Clamp the step unit result to the grid edge
  always_comb begin
    if (fwd_r) begin
      target = (step_res[STEP_W-1:0] > MAX_POS_W) ? MAX_POS : CW'(step_res[STEP_W-1:0]);
    end else begin
      target = step_res[STEP_W] ? '0 : CW'(step_res[STEP_W-1:0]);
    end
  end

  // Write port: clearing pass, else the pending mark of the walk
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt_r;
      mem_wr_data = CELL_BLANK;
    end else begin
      mem_wr_en   = pend_r && (mem_rd_data == CELL_BLANK);
      mem_wr_addr = pend_addr_r;
      mem_wr_data = horiz_r ? CELL_HORIZ : CELL_VERT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      heading_r   <= HEAD_RIGHT;
      pen_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      heading_r   <= heading_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r      <= code_nxt;
    dist_r      <= dist_nxt;
    horiz_r     <= horiz_nxt;
    fwd_r       <= fwd_nxt;
    idx_r       <= idx_nxt;
    hi_r        <= hi_nxt;
    pend_addr_r <= pend_addr_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    heading_nxt   = heading_r;
    pen_nxt       = pen_r;
    code_nxt      = code_r;
    out_valid_nxt = 1'b0;
    dist_nxt      = dist_r;
    horiz_nxt     = horiz_r;
    fwd_nxt       = fwd_r;
    idx_nxt       = idx_r;
    hi_nxt        = hi_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    clr_cnt_nxt   = clr_cnt_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = {CW'(in_read_row), CW'(in_read_col)};
    step_op       = STEP_ADD;
    step_a        = STEP_W'(idx_r);
    step_b        = STEP_W'(1);

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          code_nxt      = CELL_BLANK;
          out_valid_nxt = 1'b1;
          unique case (in_req_type)
            REQ_PEN_UP:     pen_nxt = 1'b0;
            REQ_PEN_DOWN:   pen_nxt = 1'b1;
            REQ_TURN_RIGHT: heading_nxt = heading_t'(heading_r + 2'd1);
            REQ_TURN_LEFT:  heading_nxt = heading_t'(heading_r + 2'd3);
            REQ_MOVE: begin
              out_valid_nxt = 1'b0;
              dist_nxt      = (in_steps == '0) ? '0 : in_steps - 6'd1;
              horiz_nxt     = (heading_r == HEAD_RIGHT) || (heading_r == HEAD_LEFT);
              fwd_nxt       = (heading_r == HEAD_RIGHT) || (heading_r == HEAD_DOWN);
              state_nxt     = ST_CALC;
            end
            REQ_READ: begin
              // outside the grid reads as blank without touching memory
              if ((STEP_W'(in_read_row) < GRID_W) && (STEP_W'(in_read_col) < GRID_W)) begin
                out_valid_nxt = 1'b0;
                mem_rd_en     = 1'b1;
                state_nxt     = ST_RWAIT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_CALC: begin
        step_op = fwd_r ? STEP_ADD : STEP_SUB;
        step_a  = STEP_W'(start_pos);
        step_b  = STEP_W'(dist_r);
        if (horiz_r) begin
          pos_col_nxt = target;
        end else begin
          pos_row_nxt = target;
        end
        if (pen_r) begin
          idx_nxt   = fwd_r ? start_pos : target;
          hi_nxt    = fwd_r ? target : start_pos;
          state_nxt = ST_WALK;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_WALK: begin
        // read this cell now, mark it next cycle if still blank
        mem_rd_en     = 1'b1;
        mem_rd_addr   = horiz_r ? {pos_row_r, idx_r} : {idx_r, pos_col_r};
        pend_nxt      = 1'b1;
        pend_addr_nxt = mem_rd_addr;
        if (idx_r == hi_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          idx_nxt = CW'(step_res[STEP_W-1:0]);
        end
      end

      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      ST_RWAIT: begin
        code_nxt      = mem_rd_data;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_cell_code      = code_r;
  assign out_turtle_row     = 5'(pos_row_r);
  assign out_turtle_col     = 5'(pos_col_r);
  assign out_turtle_heading = heading_r;
  assign out_pen_is_down    = pen_r;

endmodule

[hw/rtl/tgp_checker.sv]
// Port-level assertions for the turtle grid plotter, bound to the top level.
module tgp_checker import tgp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_cell_code,
  input logic [1:0] out_turtle_heading,
  input logic       out_pen_is_down
);

  // A result strobe only appears once the block is free again
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // Every accepted transaction either finishes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("accepted transaction dropped");

  // Pen and heading change only through an accepted transaction
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> ($stable(out_pen_is_down) && $stable(out_turtle_heading)))
    else $error("turtle state changed without a transaction");

  // Cell codes stay within the defined marks
  a_cell_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_code == CELL_BLANK || out_cell_code == CELL_HORIZ ||
                   out_cell_code == CELL_VERT))
    else $error("undefined cell code");

endmodule

bind turtle_grid_plotter_top tgp_checker u_tgp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_cell_code      (out_cell_code),
  .out_turtle_heading (out_turtle_heading),
  .out_pen_is_down    (out_pen_is_down)
);
